// ===== rtl/mtb_pkg.sv =====
package mtb_pkg;

  localparam int MAX_DIM_DEFAULT = 4096;

  localparam int CFG_W   = 13;
  localparam int CHAN_W  = 8;
  localparam int PIX_W   = 10;
  localparam int SUM_W   = 34;
  localparam int THR_W   = 10;
  localparam int CNT_W   = $clog2(SUM_W);
  localparam int LEVEL_W = 8;

  localparam logic [CFG_W-1:0]   DIM_RESET  = 13'd512;
  localparam logic [LEVEL_W-1:0] LEVEL_HIGH = 8'd255;
  localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 8'd0;
  localparam logic [THR_W-1:0]   THR_MAX    = 10'd1023;

  localparam int IDX_W = 2;
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic PASS_ACCUMULATE = 1'b0;
  localparam logic PASS_CLASSIFY   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accumulate;
    logic classify;
    logic latch;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic out_stall;
  } status_t;

endpackage

// ===== rtl/mtb_ctrl.sv =====
module mtb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             pass_kind,
  input  logic             frame_end,
  input  mtb_pkg::status_t status,
  output logic             in_ready,
  output mtb_pkg::cmd_t    cmd
);

  mtb_pkg::state_t state, state_next;
  logic [mtb_pkg::CNT_W-1:0] count, count_next;
  logic accept;
  logic div_last;

  assign in_ready = (state == mtb_pkg::ST_IDLE) && !status.out_stall;
  assign accept   = in_valid && in_ready;
  assign div_last = (count == mtb_pkg::CNT_W'(mtb_pkg::SUM_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtb_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    unique case (state)
      mtb_pkg::ST_IDLE: begin
        count_next = '0;
        if (accept && pass_kind == mtb_pkg::PASS_ACCUMULATE && frame_end) begin
          state_next = mtb_pkg::ST_MUL;
        end
      end
      mtb_pkg::ST_MUL: begin
        state_next = mtb_pkg::ST_DIV;
      end
      mtb_pkg::ST_DIV: begin
        count_next = count + 1'b1;
        if (div_last) begin
          state_next = mtb_pkg::ST_FINISH;
        end
      end
      mtb_pkg::ST_FINISH: begin
        state_next = mtb_pkg::ST_IDLE;
      end
      default: begin
        state_next = mtb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      mtb_pkg::ST_IDLE: begin
        cmd.accumulate = accept && pass_kind == mtb_pkg::PASS_ACCUMULATE;
        cmd.classify   = accept && pass_kind == mtb_pkg::PASS_CLASSIFY;
      end
      mtb_pkg::ST_MUL:    cmd.latch  = 1'b1;
      mtb_pkg::ST_DIV:    cmd.step   = 1'b1;
      mtb_pkg::ST_FINISH: cmd.finish = 1'b1;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/mtb_dpath.sv =====
module mtb_dpath #(
  parameter int MAX_DIM = mtb_pkg::MAX_DIM_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [mtb_pkg::IDX_W-1:0]   cfg_index,
  input  logic [mtb_pkg::CFG_W-1:0]   cfg_data,
  input  logic [mtb_pkg::CHAN_W-1:0]  red,
  input  logic [mtb_pkg::CHAN_W-1:0]  green,
  input  logic [mtb_pkg::CHAN_W-1:0]  blue,
  input  logic                        frame_end,
  input  logic                        out_ready,
  input  mtb_pkg::cmd_t               cmd,
  output mtb_pkg::status_t            status,
  output logic                        out_valid,
  output logic [mtb_pkg::LEVEL_W-1:0] level,
  output logic                        frame_done
);

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int CMP_W  = (DIM_W > mtb_pkg::CFG_W) ? DIM_W : mtb_pkg::CFG_W;
  localparam int PROD_W = 2 * DIM_W;
  localparam int SUM_W  = mtb_pkg::SUM_W;
  localparam int THR_W  = mtb_pkg::THR_W;

  logic [mtb_pkg::CFG_W-1:0] image_width;
  logic [mtb_pkg::CFG_W-1:0] image_height;
  logic [SUM_W-1:0]          channel_sum;
  logic [THR_W-1:0]          threshold;

  logic [PROD_W-1:0] divisor;
  logic [PROD_W-1:0] rem;
  logic [SUM_W-1:0]  dvd;

  logic [mtb_pkg::PIX_W-1:0] pix;
  logic [SUM_W:0]            sum_add;
  logic [SUM_W-1:0]          sum_sat;
  logic [CMP_W-1:0]          w_ext, h_ext, w_clamp, h_clamp;
  logic [PROD_W:0]           trial;
  logic                      take;
  logic [PROD_W-1:0]         rem_next;
  logic [THR_W-1:0]          thr_next;

  assign pix = mtb_pkg::PIX_W'(red) + mtb_pkg::PIX_W'(green) + mtb_pkg::PIX_W'(blue);

  assign sum_add = {1'b0, channel_sum} + (SUM_W + 1)'(pix);
  assign sum_sat = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];

  // zero counts as one, anything past MAX_DIM as MAX_DIM
  always_comb begin
    w_ext = CMP_W'(image_width);
    h_ext = CMP_W'(image_height);
    priority if (w_ext == '0) w_clamp = CMP_W'(1);
    else if (w_ext > CMP_W'(MAX_DIM)) w_clamp = CMP_W'(MAX_DIM);
    else w_clamp = w_ext;
    priority if (h_ext == '0) h_clamp = CMP_W'(1);
    else if (h_ext > CMP_W'(MAX_DIM)) h_clamp = CMP_W'(MAX_DIM);
    else h_clamp = h_ext;
  end

  // restoring division, one quotient bit per cycle, MSB first
  assign trial    = {rem, dvd[SUM_W-1]};
  assign take     = trial >= {1'b0, divisor};
  assign rem_next = take ? PROD_W'(trial - {1'b0, divisor}) : trial[PROD_W-1:0];

  assign thr_next = (|dvd[SUM_W-1:THR_W]) ? mtb_pkg::THR_MAX : dvd[THR_W-1:0];

  assign status.out_stall = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= mtb_pkg::DIM_RESET;
      image_height <= mtb_pkg::DIM_RESET;
      channel_sum  <= '0;
      threshold    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write && cfg_index == mtb_pkg::REG_IMAGE_WIDTH) begin
        image_width <= cfg_data;
      end
      if (cfg_write && cfg_index == mtb_pkg::REG_IMAGE_HEIGHT) begin
        image_height <= cfg_data;
      end
      if (cmd.accumulate) begin
        channel_sum <= sum_sat;
      end else if (cmd.latch) begin
        channel_sum <= '0;
      end
      if (cmd.finish) begin
        threshold <= thr_next;
      end
      if (cmd.classify) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      divisor <= PROD_W'(w_clamp[DIM_W-1:0]) * PROD_W'(h_clamp[DIM_W-1:0]);
      dvd     <= channel_sum;
      rem     <= '0;
    end else if (cmd.step) begin
      rem <= rem_next;
      dvd <= {dvd[SUM_W-2:0], take};
    end
    if (cmd.classify) begin
      level      <= (THR_W'(pix) < threshold) ? mtb_pkg::LEVEL_LOW : mtb_pkg::LEVEL_HIGH;
      frame_done <= frame_end;
    end
  end

endmodule

// ===== rtl/mean_threshold_binarize.sv =====
// Mean-threshold binarizer for RGB frames, two passes per frame.
// Input channel (in_valid/in_ready): one pixel per beat with pass_kind and
// frame_end. Accumulate-pass beats (pass_kind 0) add red+green+blue to a
// saturating sum and give no result. The beat with frame_end set ends the
// pass: the sum is divided by the clamped image_width*image_height and the
// floored mean, capped at 1023, becomes the threshold.
// Classify-pass beats (pass_kind 1) each give one beat on the output channel
// (out_valid/out_ready): level 0 below the threshold, 255 otherwise, with
// frame_done copying frame_end. The result appears the cycle after accept.
// Throughput is one pixel per cycle in both passes while the output is not
// stalled. After the last accumulate beat in_ready stays low while the
// divisor multiply, the bit-serial divider and the threshold store run.
// A stalled output register holds its beat and in_ready drops until it
// is taken. Reset sets both dimensions to 512 and clears sum and threshold;
// classifying before any accumulate pass gives 255 everywhere.
// cfg_write stores cfg_data into register cfg_index (0 width, 1 height).
module mean_threshold_binarize #(
  parameter int MAX_DIM = mtb_pkg::MAX_DIM_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [mtb_pkg::IDX_W-1:0]   cfg_index,
  input  logic [mtb_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mtb_pkg::CHAN_W-1:0]  red,
  input  logic [mtb_pkg::CHAN_W-1:0]  green,
  input  logic [mtb_pkg::CHAN_W-1:0]  blue,
  input  logic                        pass_kind,
  input  logic                        frame_end,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mtb_pkg::LEVEL_W-1:0] level,
  output logic                        frame_done
);

  mtb_pkg::cmd_t    cmd;
  mtb_pkg::status_t status;

  mtb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .pass_kind (pass_kind),
    .frame_end (frame_end),
    .status    (status),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  mtb_dpath #(
    .MAX_DIM (MAX_DIM)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .frame_end  (frame_end),
    .out_ready  (out_ready),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_valid),
    .level      (level),
    .frame_done (frame_done)
  );

`ifndef SYNTHESIS
  a_div_blocks_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && pass_kind == mtb_pkg::PASS_ACCUMULATE && frame_end
    |=> !in_ready)
    else $error("input not held off after end of accumulate pass");

  a_classify_gives_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && pass_kind == mtb_pkg::PASS_CLASSIFY |=> out_valid)
    else $error("classify beat produced no result");

  a_level_binary: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (level == mtb_pkg::LEVEL_LOW || level == mtb_pkg::LEVEL_HIGH))
    else $error("level is neither 0 nor 255");
`endif

endmodule
